>>> hw/rtl/nvr_pkg.sv
// shared constants and types of the nearest-neighbour volume resampler
package nvr_pkg;

    // sizing
    localparam int MAX_SRC_DIM = 64;
    localparam int MAX_DST_DIM = 256;
    localparam int SAMPLE_BITS = 32;

    // fixed field widths
    localparam int VOXEL_BITS = 32;
    localparam int OLD_CFG_W  = 7;
    localparam int NEW_CFG_W  = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 3;

    // derived widths
    localparam int SRC_IDX_W   = $clog2(MAX_SRC_DIM);
    localparam int ADDR_W      = 3 * SRC_IDX_W;
    localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int TOT_W       = ADDR_W + 1;
    localparam int EOLD_W      = $clog2(MAX_SRC_DIM + 1);
    localparam int ENEW_W      = $clog2(MAX_DST_DIM + 1);
    localparam int DST_W       = $clog2(MAX_DST_DIM);
    localparam int NUM_W       = $clog2(2 * (MAX_DST_DIM - 1) * MAX_SRC_DIM + MAX_DST_DIM + 1);
    localparam int DEN_W       = $clog2(2 * MAX_DST_DIM + 1);
    localparam int CNT_W       = $clog2(NUM_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LABEL = 3'd6;

    // item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // control of the index division lanes
    typedef struct packed {
        logic start;
        logic step;
    } t_div_ctrl;

endpackage

>>> hw/rtl/nvr_idx_div.sv
// one axis lane: bit-serial round(n*old/new) with clamp to old-1
module nvr_idx_div
    import nvr_pkg::*;
(
    input  logic                  i_clk,
    input  t_div_ctrl             i_ctrl,
    input  logic [DST_W-1:0]      i_coord,
    input  logic [EOLD_W-1:0]     i_old,
    input  logic [ENEW_W-1:0]     i_new,
    output logic [SRC_IDX_W-1:0]  o_idx
);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [EOLD_W-1:0] r_old;

    logic [NUM_W-1:0]  n_num_init;
    logic [DEN_W:0]    n_rem_sh;
    logic              n_qbit;
    logic [DEN_W:0]    n_rem_sub;

    // numerator 2*n*old + new, divisor 2*new
    assign n_num_init = NUM_W'({i_coord, 1'b0}) * NUM_W'(i_old) + NUM_W'(i_new);

    assign n_rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign n_qbit    = (n_rem_sh >= {1'b0, r_den});
    assign n_rem_sub = n_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_num <= n_num_init;
            r_rem <= '0;
            r_den <= DEN_W'({i_new, 1'b0});
            r_old <= i_old;
        end else if (i_ctrl.step) begin
            r_num <= {r_num[NUM_W-2:0], n_qbit};
            r_rem <= n_qbit ? n_rem_sub[DEN_W-1:0] : n_rem_sh[DEN_W-1:0];
        end
    end

    // quotient sits in r_num once all steps are done
    always_comb begin
        if (r_num >= NUM_W'(r_old)) begin
            o_idx = SRC_IDX_W'(r_old - EOLD_W'(1));
        end else begin
            o_idx = r_num[SRC_IDX_W-1:0];
        end
    end

endmodule

>>> hw/rtl/nearest_volume_resampler.sv
// top level of the nearest-neighbour volume resampler
// load items: one per cycle while idle and no configuration write is settling,
//   written straight into the source store, no result
// fetch items: one at a time; the result follows the 16-step bit-serial index
//   division per axis, then two address multiply steps and the store read
// reset: synchronous active low; resets pointers, position, state and config
//   registers; the source store holds no reset value and needs no clearing pass
module nearest_volume_resampler
    import nvr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,  // [31:0] sample
    input  logic                   s_axis_tuser,  // [0] opcode
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [VOXEL_BITS-1:0]  m_axis_tdata,  // [31:0] voxel
    output logic                   m_axis_tlast
);

    // fetch sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ADDR1 = 3'd2;
    localparam logic [2:0] ST_ADDR2 = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);
    localparam int A1_W = 2 * SRC_IDX_W;

    // label rounding works in a width with headroom for the half-add and negate
    localparam int LW = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 2;
    localparam logic signed [LW-1:0] LBL_ONE  = LW'(1);
    localparam logic signed [LW-1:0] LBL_RND  = LW'(32768);
    localparam logic signed [LW-1:0] LBL_MASK = ~LW'(65535);
    localparam logic signed [LW-1:0] LBL_HI   =
        ((LBL_ONE <<< (SAMPLE_BITS - 1)) - LBL_ONE) & LBL_MASK;
    localparam logic signed [LW-1:0] LBL_LO   =
        -((LBL_ONE <<< (SAMPLE_BITS - 1)) & LBL_MASK);

    function automatic logic [EOLD_W-1:0] eff_old(input logic [OLD_CFG_W-1:0] v);
        logic [EOLD_W-1:0] r;
        if (v == '0) begin
            r = EOLD_W'(1);
        end else if (32'(v) > MAX_SRC_DIM) begin
            r = EOLD_W'(MAX_SRC_DIM);
        end else begin
            r = EOLD_W'(v);
        end
        return r;
    endfunction

    function automatic logic [ENEW_W-1:0] eff_new(input logic [NEW_CFG_W-1:0] v);
        logic [ENEW_W-1:0] r;
        if (v == '0) begin
            r = ENEW_W'(1);
        end else if (32'(v) > MAX_DST_DIM) begin
            r = ENEW_W'(MAX_DST_DIM);
        end else begin
            r = ENEW_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] label_round(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        logic signed [LW-1:0] w;
        logic signed [LW-1:0] r;
        w = LW'(v);
        if (w >= 0) begin
            r = (w + LBL_RND) & LBL_MASK;
        end else begin
            r = -((-w + LBL_RND) & LBL_MASK);
        end
        if (r > LBL_HI) begin
            r = LBL_HI;
        end
        if (r < LBL_LO) begin
            r = LBL_LO;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // configuration registers
    logic [OLD_CFG_W-1:0] r_old_x, r_old_y, r_old_z;
    logic [NEW_CFG_W-1:0] r_new_x, r_new_y, r_new_z;
    logic                 r_label;
    logic [1:0]           r_settle;

    // volume size pipeline, kept in step with the extents
    logic [2*EOLD_W-1:0]  r_oxy;
    logic [TOT_W-1:0]     r_total;

    // stream position
    logic [ADDR_W-1:0]    r_load_ptr;
    logic [DST_W-1:0]     r_out_x, r_out_y, r_out_z;

    // fetch sequencer
    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [A1_W-1:0]      r_a1;
    logic [ADDR_W-1:0]    r_addr;

    // source store and its registered read data
    logic [SAMPLE_BITS-1:0] r_store [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] r_rd;

    // output register
    logic                   r_m_valid;
    logic [VOXEL_BITS-1:0]  r_m_data;
    logic                   r_m_last;

    logic [EOLD_W-1:0]     eox, eoy, eoz;
    logic [ENEW_W-1:0]     enx, eny, enz;
    logic                  in_acc, load_acc, fetch_acc;
    logic                  end_x, end_y, end_z, vox_last;
    logic                  out_free, out_fire;
    logic [TOT_W-1:0]      n_load_next;
    logic [SRC_IDX_W-1:0]  idx_x, idx_y, idx_z;
    logic signed [SAMPLE_BITS-1:0] rd_s, vox_s;
    t_div_ctrl             div_ctrl;

    assign eox = eff_old(r_old_x);
    assign eoy = eff_old(r_old_y);
    assign eoz = eff_old(r_old_z);
    assign enx = eff_new(r_new_x);
    assign eny = eff_new(r_new_y);
    assign enz = eff_new(r_new_z);

    // input waits while the volume size catches up with a configuration write
    assign s_axis_tready = (r_state == ST_IDLE) && (r_settle == 2'd0);
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign load_acc  = in_acc && (s_axis_tuser == OP_LOAD);
    assign fetch_acc = in_acc && (s_axis_tuser == OP_FETCH);

    // a coordinate at or past its extent minus one counts as the final one
    assign end_z    = (ENEW_W'(r_out_z) + ENEW_W'(1)) >= enz;
    assign end_y    = (ENEW_W'(r_out_y) + ENEW_W'(1)) >= eny;
    assign end_x    = (ENEW_W'(r_out_x) + ENEW_W'(1)) >= enx;
    assign vox_last = end_x && end_y && end_z;

    assign n_load_next = TOT_W'(r_load_ptr) + TOT_W'(1);

    assign out_free = !r_m_valid || m_axis_tready;
    assign out_fire = (r_state == ST_OUT) && out_free;

    assign div_ctrl.start = fetch_acc;
    assign div_ctrl.step  = (r_state == ST_DIV);

    nvr_idx_div u_div_x (
        .i_clk   (i_clk),
        .i_ctrl  (div_ctrl),
        .i_coord (r_out_x),
        .i_old   (eox),
        .i_new   (enx),
        .o_idx   (idx_x)
    );

    nvr_idx_div u_div_y (
        .i_clk   (i_clk),
        .i_ctrl  (div_ctrl),
        .i_coord (r_out_y),
        .i_old   (eoy),
        .i_new   (eny),
        .o_idx   (idx_y)
    );

    nvr_idx_div u_div_z (
        .i_clk   (i_clk),
        .i_ctrl  (div_ctrl),
        .i_coord (r_out_z),
        .i_old   (eoz),
        .i_new   (enz),
        .o_idx   (idx_z)
    );

    // configuration writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_x  <= OLD_CFG_W'(64);
            r_old_y  <= OLD_CFG_W'(64);
            r_old_z  <= OLD_CFG_W'(64);
            r_new_x  <= NEW_CFG_W'(64);
            r_new_y  <= NEW_CFG_W'(64);
            r_new_z  <= NEW_CFG_W'(64);
            r_label  <= 1'b0;
            r_settle <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_settle <= 2'd2;
                unique case (i_cfg_idx)
                    CFG_OLD_X: r_old_x <= i_cfg_data[OLD_CFG_W-1:0];
                    CFG_OLD_Y: r_old_y <= i_cfg_data[OLD_CFG_W-1:0];
                    CFG_OLD_Z: r_old_z <= i_cfg_data[OLD_CFG_W-1:0];
                    CFG_NEW_X: r_new_x <= i_cfg_data[NEW_CFG_W-1:0];
                    CFG_NEW_Y: r_new_y <= i_cfg_data[NEW_CFG_W-1:0];
                    CFG_NEW_Z: r_new_z <= i_cfg_data[NEW_CFG_W-1:0];
                    CFG_LABEL: r_label <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // source volume size, one multiply per stage
    always_ff @(posedge i_clk) begin
        r_oxy   <= (2*EOLD_W)'(eox) * (2*EOLD_W)'(eoy);
        r_total <= TOT_W'(r_oxy) * TOT_W'(eoz);
    end

    // source store: loads write at the pointer, the sequencer reads one entry
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_store[r_load_ptr] <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (r_state == ST_READ) begin
            r_rd <= r_store[r_addr];
        end
    end

    // load pointer wraps after the last sample of the volume
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_ptr <= '0;
        end else if (load_acc) begin
            if (n_load_next >= r_total) begin
                r_load_ptr <= '0;
            end else begin
                r_load_ptr <= n_load_next[ADDR_W-1:0];
            end
        end
    end

    // fetch sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (fetch_acc) begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == DIV_LAST) begin
                        r_state <= ST_ADDR1;
                    end
                end
                ST_ADDR1: r_state <= ST_ADDR2;
                ST_ADDR2: r_state <= ST_READ;
                ST_READ:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // store address ((sx*oy + sy)*oz + sz), split over two stages
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR1) begin
            r_a1 <= A1_W'(idx_x) * A1_W'(eoy) + A1_W'(idx_y);
        end
        if (r_state == ST_ADDR2) begin
            r_addr <= ADDR_W'(r_a1) * ADDR_W'(eoz) + ADDR_W'(idx_z);
        end
    end

    // output position, z innermost
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_x <= '0;
            r_out_y <= '0;
            r_out_z <= '0;
        end else if (out_fire) begin
            if (!end_z) begin
                r_out_z <= r_out_z + DST_W'(1);
            end else begin
                r_out_z <= '0;
                if (!end_y) begin
                    r_out_y <= r_out_y + DST_W'(1);
                end else begin
                    r_out_y <= '0;
                    r_out_x <= end_x ? '0 : (r_out_x + DST_W'(1));
                end
            end
        end
    end

    // label mode rounds to a multiple of 65536, half away from zero, and saturates
    assign rd_s  = r_rd;
    assign vox_s = r_label ? label_round(rd_s) : rd_s;

    // output register, holds an item until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_fire) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            r_m_data <= VOXEL_BITS'(vox_s);
            r_m_last <= vox_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule
